// ----- rtl/core/mrsq_pkg.sv -----
`timescale 1ns / 1ps

package mrsq_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SUM_W   = 44;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  // Reset value of both dimension registers.
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  typedef struct packed {
    logic                      func;
    logic signed [ELEM_W-1:0]  element_value;
    logic                      first_element;
    logic [COORD_W-1:0]        top_row;
    logic [COORD_W-1:0]        left_col;
    logic [COORD_W-1:0]        bottom_row;
    logic [COORD_W-1:0]        right_col;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rect_sum;
    logic                    status;
  } out_item_t;

endpackage

// ----- rtl/core/matrix_rectangle_sum_query.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data  (mrsq_pkg::in_item_t)
// out      output     out_valid / out_ready  out_data (mrsq_pkg::out_item_t)
// cfg      input      cfg_we                 cfg_addr, cfg_wdata
//
// A load item's row prefix is formed and written to the prefix memory when it is accepted.
// For a query item, two read ports fetch one row per cycle and a single shared adder folds
// each row into the total.
// A query with bad bounds skips the row reads. The input is not ready while a query runs.
// Reset zeroes the load position and running row sum and sets both dimensions to 64.
// A result waits in the output register while loads go on; a query ends once it is free.
module matrix_rectangle_sum_query #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mrsq_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mrsq_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mrsq_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mrsq_pkg::CFG_W-1:0]          cfg_wdata
);
  import mrsq_pkg::*;

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Columns in use never exceed what the dimension register can hold.
  localparam int unsigned COLS_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int unsigned PW = ELEM_W + $clog2(COLS_CAP);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [CFG_W-1:0] rows_eff, cols_eff;

  logic [RW-1:0] lrow_r;
  logic [CW-1:0] lcol_r;
  logic signed [PW-1:0] running_r;

  logic signed [PW-1:0] mem [DEPTH];
  logic signed [PW-1:0] rd_a_r, rd_b_r;

  logic [RW-1:0] qrow_r, qbottom_r;
  logic [CW-1:0] qright_r, qleftm1_r;
  logic          qleft_zero_r;
  logic          pend_r;
  logic          err_r;
  logic signed [SUM_W-1:0] acc_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic in_acc, is_load, is_query, bad_bounds;

  // Dimension registers as used: zero reads as one, oversize as the maximum.
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = CFG_W'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = CFG_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_r;
    end
    if (cols_cfg_r == '0) begin
      cols_eff = CFG_W'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = CFG_W'(MAX_COLS);
    end else begin
      cols_eff = cols_cfg_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_load  = in_acc && (in_data.func == FUNC_LOAD);
  assign is_query = in_acc && (in_data.func == FUNC_QUERY);

  assign bad_bounds = (in_data.top_row > in_data.bottom_row) ||
                      (in_data.left_col > in_data.right_col) ||
                      (CFG_W'(in_data.bottom_row) >= rows_eff) ||
                      (CFG_W'(in_data.right_col) >= cols_eff);

  // Load position: restart, wrap a stale position, then step past the stored element.
  logic [RW:0] r0, r1;
  logic [CW:0] c0, c1;
  logic signed [PW-1:0] running_nxt;
  logic [AW-1:0] wr_addr;

  always_comb begin
    r0 = in_data.first_element ? '0 : {1'b0, lrow_r};
    c0 = in_data.first_element ? '0 : {1'b0, lcol_r};
    if (c0 >= (CW+1)'(cols_eff)) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= (RW+1)'(rows_eff)) begin
      r0 = '0;
    end
    r1 = r0;
    c1 = c0 + 1'b1;
    if (c1 >= (CW+1)'(cols_eff)) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      if (r1 >= (RW+1)'(rows_eff)) begin
        r1 = '0;
      end
    end
    if (c0 == '0) begin
      running_nxt = PW'(in_data.element_value);
    end else begin
      running_nxt = running_r + PW'(in_data.element_value);
    end
    wr_addr = AW'(32'(r0[RW-1:0]) * MAX_COLS + 32'(c0[CW-1:0]));
  end

  // Read addresses for the row being issued.
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  assign rd_a_addr = AW'(32'(qrow_r) * MAX_COLS + 32'(qright_r));
  assign rd_b_addr = AW'(32'(qrow_r) * MAX_COLS + 32'(qleftm1_r));

  // Prefix memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (is_load) begin
      mem[wr_addr] <= running_nxt;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_query) begin
          state_nxt = bad_bounds ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (qrow_r == qbottom_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state: sequencer, dimension registers, load position and running row sum, read-pending flag, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= CFG_DIM_RESET;
      cols_cfg_r  <= CFG_DIM_RESET;
      lrow_r      <= '0;
      lcol_r      <= '0;
      running_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_ROWS_IN_USE: rows_cfg_r <= cfg_wdata;
          CFG_COLS_IN_USE: cols_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (is_load) begin
        lrow_r    <= r1[RW-1:0];
        lcol_r    <= c1[CW-1:0];
        running_r <= running_nxt;
      end
      pend_r <= (state_r == S_RUN);
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Query registers, the shared accumulate adder and the output data register.
  always_ff @(posedge clk) begin
    if (is_query) begin
      qrow_r       <= RW'(in_data.top_row);
      qbottom_r    <= RW'(in_data.bottom_row);
      qright_r     <= CW'(in_data.right_col);
      qleftm1_r    <= (in_data.left_col == '0) ? '0 : CW'(in_data.left_col - 1'b1);
      qleft_zero_r <= (in_data.left_col == '0);
      err_r        <= bad_bounds;
      acc_r        <= '0;
    end else begin
      if (state_r == S_RUN) begin
        qrow_r <= qrow_r + 1'b1;
      end
      if (pend_r) begin
        acc_r <= acc_r + SUM_W'(rd_a_r) - (qleft_zero_r ? '0 : SUM_W'(rd_b_r));
      end
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_data_r.rect_sum <= err_r ? '0 : acc_r;
      out_data_r.status   <= err_r ? STATUS_ERR : STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sim/rect_sum_scoreboard_pkg.sv -----
`timescale 1ns / 1ps

package rect_sum_scoreboard_pkg;
  import mrsq_pkg::*;

  // Matrix size the block is built with in this bench.
  localparam int unsigned DIM_MAX = 64;

  class rect_sum_scoreboard;
    // Mirror of the block's row prefix memory, plus which entries hold data.
    longint prefix_mem [DIM_MAX*DIM_MAX];
    bit written [DIM_MAX*DIM_MAX];
    longint row_sum;
    int unsigned load_r;
    int unsigned load_c;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    out_item_t pending_sums [$];
    int unsigned fail_count;

    function new();
      foreach (written[i]) begin
        written[i] = 1'b0;
        prefix_mem[i] = 0;
      end
      row_sum = 0;
      load_r = 0;
      load_c = 0;
      rows_reg = CFG_DIM_RESET;
      cols_reg = CFG_DIM_RESET;
      fail_count = 0;
    endfunction

    // A zero dimension acts as one, anything above the build size as the build size.
    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return v;
    endfunction

    function int unsigned rows_used();
      return eff_dim(rows_reg);
    endfunction

    function int unsigned cols_used();
      return eff_dim(cols_reg);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ROWS_IN_USE) rows_reg = val;
      else if (idx == CFG_COLS_IN_USE) cols_reg = val;
    endfunction

    function bit bounds_bad(in_item_t it);
      return (it.top_row > it.bottom_row) || (it.left_col > it.right_col) ||
             (it.bottom_row >= rows_used()) || (it.right_col >= cols_used());
    endfunction

    // True when a query touches only entries that have been loaded.
    function bit reads_written(in_item_t it);
      int unsigned r;
      if (bounds_bad(it)) return 1'b1;
      for (r = it.top_row; r <= it.bottom_row; r++) begin
        if (!written[r*DIM_MAX + it.right_col]) return 1'b0;
        if (it.left_col != 0 && !written[r*DIM_MAX + it.left_col - 1]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Update the mirrored state for an accepted item and, for a query, queue its expected sum.
    function void note_input(in_item_t it);
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      longint total;
      out_item_t res;
      rows = rows_used();
      cols = cols_used();
      if (it.func == FUNC_LOAD) begin
        if (it.first_element) begin
          load_r = 0;
          load_c = 0;
        end
        // A position left outside the matrix by a dimension change wraps first.
        if (load_c >= cols) begin
          load_c = 0;
          load_r++;
        end
        if (load_r >= rows) load_r = 0;
        if (load_c == 0) row_sum = longint'($signed(it.element_value));
        else row_sum += longint'($signed(it.element_value));
        prefix_mem[load_r*DIM_MAX + load_c] = row_sum;
        written[load_r*DIM_MAX + load_c] = 1'b1;
        load_c++;
        if (load_c >= cols) begin
          load_c = 0;
          load_r++;
          if (load_r >= rows) load_r = 0;
        end
        return;
      end
      res.rect_sum = '0;
      res.status = STATUS_ERR;
      if (!bounds_bad(it)) begin
        total = 0;
        for (r = it.top_row; r <= it.bottom_row; r++) begin
          total += prefix_mem[r*DIM_MAX + it.right_col];
          if (it.left_col != 0) total -= prefix_mem[r*DIM_MAX + it.left_col - 1];
        end
        res.rect_sum = total[SUM_W-1:0];
        res.status = STATUS_OK;
      end
      pending_sums.push_back(res);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      fail_count++;
    endtask

    // Compare a delivered sum with the oldest one still pending.
    task check_result(out_item_t got);
      out_item_t want;
      if (pending_sums.size() == 0) begin
        report($sformatf("unexpected item: sum %0d status %0b", got.rect_sum, got.status));
        return;
      end
      want = pending_sums.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0b, expected %0b", got.status, want.status));
      if (got.rect_sum !== want.rect_sum)
        report($sformatf("rect_sum %0d, expected %0d", got.rect_sum, want.rect_sum));
    endtask
  endclass
endpackage

// ----- sim/matrix_rectangle_sum_query_tb.sv -----
`timescale 1ns / 1ps

module matrix_rectangle_sum_query_tb;
  import mrsq_pkg::*;
  import rect_sum_scoreboard_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned MIXED_PER_PHASE = 45;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;
  int unsigned hold_left;
  int unsigned filled_rows;
  int unsigned random_sent;

  rect_sum_scoreboard sb = new();

  matrix_rectangle_sum_query #(
    .MAX_ROWS(DIM_MAX),
    .MAX_COLS(DIM_MAX)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check each delivered item, then pick the next ready level.
  initial begin
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item after a random gap and wait until the block takes it.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Let every pending sum come back and the last load finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both dimension registers on back-to-back cycles.
  task automatic set_dims(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_ROWS_IN_USE;
    cfg_wdata <= rows_val;
    @(posedge clk);
    sb.note_config(CFG_ROWS_IN_USE, rows_val);
    cfg_addr <= CFG_COLS_IN_USE;
    cfg_wdata <= cols_val;
    @(posedge clk);
    sb.note_config(CFG_COLS_IN_USE, cols_val);
    cfg_we <= 1'b0;
  endtask

  // Loads carry random bounds, which the block ignores.
  function automatic in_item_t load_item(input logic first, input logic [ELEM_W-1:0] value);
    in_item_t it;
    it.func = FUNC_LOAD;
    it.element_value = value;
    it.first_element = first;
    it.top_row = COORD_W'($urandom_range(63));
    it.left_col = COORD_W'($urandom_range(63));
    it.bottom_row = COORD_W'($urandom_range(63));
    it.right_col = COORD_W'($urandom_range(63));
    return it;
  endfunction

  // Queries carry a random element and restart flag, which the block ignores.
  function automatic in_item_t query_item(input int unsigned t, input int unsigned l,
                                          input int unsigned b, input int unsigned r);
    in_item_t it;
    it.func = FUNC_QUERY;
    it.element_value = ELEM_W'($urandom());
    it.first_element = 1'($urandom_range(1));
    it.top_row = COORD_W'(t);
    it.left_col = COORD_W'(l);
    it.bottom_row = COORD_W'(b);
    it.right_col = COORD_W'(r);
    return it;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // Mostly small dimensions, sometimes zero, full size or beyond.
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return 7'd64;
    if (p < 22) return CFG_W'($urandom_range(127, 65));
    return CFG_W'($urandom_range(8, 1));
  endfunction

  // A rectangle inside the rows this phase has filled completely.
  function automatic in_item_t valid_query();
    int unsigned cols;
    int unsigned t;
    int unsigned b;
    int unsigned l;
    int unsigned r;
    cols = sb.cols_used();
    t = $urandom_range(filled_rows - 1);
    b = $urandom_range(filled_rows - 1, t);
    l = ($urandom_range(3) == 0) ? 0 : $urandom_range(cols - 1);
    r = $urandom_range(cols - 1, l);
    return query_item(t, l, b, r);
  endfunction

  // Arbitrary bounds, kept only if they never touch an unloaded entry.
  function automatic in_item_t noisy_query();
    in_item_t it;
    int tries;
    for (tries = 0; tries < 32; tries++) begin
      it = query_item($urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(63));
      if (sb.reads_written(it)) return it;
    end
    return valid_query();
  endfunction

  // One random phase: new dimensions, a fill pass, then mixed loads and queries.
  task automatic run_phase(input int unsigned mode, input bit with_hold);
    int unsigned fill;
    int unsigned k;
    int unsigned pick;
    settle();
    set_dims(pick_dim(), pick_dim());
    case (mode)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 63;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 63;
      end
      default: begin
        idle_pct = 26;
        stall_pct = 26;
      end
    endcase
    filled_rows = sb.rows_used();
    fill = filled_rows * sb.cols_used();
    // Large matrices get only their first rows loaded to keep the run short.
    if (fill > 256) begin
      filled_rows = 3;
      fill = filled_rows * sb.cols_used();
    end
    for (k = 0; k < fill; k++) send_item(load_item(k == 0, rand_element()));
    if (with_hold) hold_len = HOLD_OFF_CYCLES;
    for (k = 0; k < MIXED_PER_PHASE; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) send_item(load_item($urandom_range(19) == 0, rand_element()));
      else if (pick < 88) send_item(valid_query());
      else send_item(noisy_query());
    end
    random_sent += fill + MIXED_PER_PHASE;
  endtask

  initial begin
    int unsigned p;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    filled_rows = 1;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A 2x3 matrix of extreme values, one wrapping load, good and bad rectangles.
    settle();
    set_dims(7'd2, 7'd3);
    send_item(load_item(1'b1, 32'h7FFF_FFFF));
    send_item(load_item(1'b0, 32'h8000_0000));
    send_item(load_item(1'b0, 32'h7FFF_FFFF));
    send_item(load_item(1'b0, 32'h8000_0000));
    send_item(load_item(1'b0, 32'hFFFF_FFFF));
    send_item(load_item(1'b0, 32'h0000_0001));
    send_item(load_item(1'b0, 32'h1234_5678));
    send_item(query_item(0, 0, 1, 2));
    send_item(query_item(0, 1, 1, 2));
    send_item(query_item(1, 2, 1, 2));
    send_item(query_item(1, 0, 0, 2));
    send_item(query_item(0, 2, 1, 1));
    send_item(query_item(0, 0, 2, 2));
    send_item(query_item(0, 0, 1, 3));
    send_item(query_item(63, 63, 63, 63));

    // Zero dimensions act as 1x1; the stale load position wraps back to the origin.
    settle();
    set_dims(7'd0, 7'd0);
    send_item(load_item(1'b0, 32'h0000_0005));
    send_item(query_item(0, 0, 0, 0));
    send_item(load_item(1'b0, 32'h8000_0000));
    send_item(query_item(0, 0, 0, 0));
    send_item(query_item(0, 0, 0, 1));

    // Oversized dimensions clamp to full size; earlier entries are still there.
    settle();
    set_dims(7'd127, 7'd127);
    send_item(query_item(0, 0, 1, 2));
    send_item(query_item(1, 1, 1, 2));
    send_item(query_item(63, 63, 62, 63));
    send_item(load_item(1'b1, 32'h7FFF_FFFF));
    send_item(query_item(0, 0, 0, 0));

    // Random phases cycle through the idle patterns; the first one holds off the output.
    for (p = 0; random_sent < RANDOM_ITEMS || p < 8; p++) run_phase(p % 4, p == 0);

    settle();
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/mrsq_pkg.sv
rtl/core/matrix_rectangle_sum_query.sv
sim/rect_sum_scoreboard_pkg.sv
sim/matrix_rectangle_sum_query_tb.sv
